/* design/lpm_pkg.sv */
// Shared types, constants and helpers for the IPv4 longest-prefix-match table.
// Used by lpm_cell, lpm_ctrl and ipv4_longest_prefix_match_table.
package lpm_pkg;

    // Default number of entries in the table.
    localparam int LPM_ENTRIES = 64;

    // Widest prefix length in bits.
    localparam logic [5:0] LPM_MAX_LEN = 6'd32;

    // Value returned when nothing matches.
    localparam logic [31:0] LPM_ALL_ONES = 32'hFFFF_FFFF;

    // Operation codes carried on the input channel.
    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_ADD    = 2'd1,
        OP_DELETE = 2'd2,
        OP_NONE   = 2'd3
    } lpm_op_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_WALK,
        ST_DONE
    } lpm_state_t;

    // Query held steady for the whole walk along the chain.
    typedef struct packed {
        logic [31:0] address;
        logic [5:0]  len;
        logic [31:0] key;
    } lpm_query_t;

    // Token that walks from cell to cell, one cell per cycle.
    typedef struct packed {
        logic        active;
        logic        hit;
        logic [5:0]  best_len;
        logic [31:0] best_value;
        logic        exact_seen;
        logic        free_seen;
    } lpm_carry_t;

    // Update broadcast to every cell once the walk is finished.
    typedef struct packed {
        logic        write_exact;
        logic        write_free;
        logic        clear_exact;
        logic [31:0] key;
        logic [5:0]  len;
        logic [31:0] value;
    } lpm_cmd_t;

    // Network mask of the given length, most significant bit first.
    function automatic logic [31:0] prefix_mask(input logic [5:0] len);
        logic [31:0] mask;
        if (len == 6'd0) begin
            mask = 32'd0;
        end else if (len >= LPM_MAX_LEN) begin
            mask = LPM_ALL_ONES;
        end else begin
            mask = ~(LPM_ALL_ONES >> len[4:0]);
        end
        return mask;
    endfunction

endpackage

/* design/lpm_cell.sv */
// One table entry with its match logic and a stage of the search token chain.
// Depends on lpm_pkg.
module lpm_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  lpm_pkg::lpm_query_t query,
    input  lpm_pkg::lpm_cmd_t   cmd,
    input  lpm_pkg::lpm_carry_t carry_in,
    output lpm_pkg::lpm_carry_t carry_out
);
    import lpm_pkg::*;

    logic        valid_reg;
    logic [31:0] key_reg;
    logic [5:0]  len_reg;
    logic [31:0] value_reg;
    logic        exact_mark_reg;
    logic        free_mark_reg;
    lpm_carry_t  carry_reg;
    lpm_carry_t  carry_next;

    logic        prefix_hit;
    logic        exact_hit;
    logic        take_best;

    // Compare this entry against the held query.
    always_comb
    begin
        prefix_hit = valid_reg && (len_reg <= query.len)
                     && (key_reg == (query.address & prefix_mask(len_reg)));
        exact_hit  = valid_reg && (len_reg == query.len) && (key_reg == query.key);
        take_best  = prefix_hit && (!carry_in.hit || (len_reg > carry_in.best_len));
    end

    // Merge this entry into the passing token.
    always_comb
    begin
        carry_next            = carry_in;
        carry_next.exact_seen = carry_in.exact_seen || exact_hit;
        carry_next.free_seen  = carry_in.free_seen || !valid_reg;
        if (take_best) begin
            carry_next.hit        = 1'b1;
            carry_next.best_len   = len_reg;
            carry_next.best_value = value_reg;
        end
        if (!carry_in.active) begin
            carry_next = '0;
        end
    end

    // Token stage and the marks that say which cell an update is meant for.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            carry_reg      <= '0;
            exact_mark_reg <= 1'b0;
            free_mark_reg  <= 1'b0;
        end else begin
            carry_reg <= carry_next;
            if (carry_in.active) begin
                exact_mark_reg <= exact_hit && !carry_in.exact_seen;
                free_mark_reg  <= !valid_reg && !carry_in.free_seen;
            end
        end
    end

    // Entry valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else if (cmd.write_free && free_mark_reg) begin
            valid_reg <= 1'b1;
        end else if (cmd.clear_exact && exact_mark_reg) begin
            valid_reg <= 1'b0;
        end
    end

    // Entry contents.
    always_ff @(posedge clk)
    begin
        if (cmd.write_free && free_mark_reg) begin
            key_reg   <= cmd.key;
            len_reg   <= cmd.len;
            value_reg <= cmd.value;
        end else if (cmd.write_exact && exact_mark_reg) begin
            value_reg <= cmd.value;
        end
    end

    assign carry_out = carry_reg;

endmodule

/* design/lpm_ctrl.sv */
// Transaction controller: takes requests, launches the search token,
// decides the table update and holds the result. Depends on lpm_pkg.
module lpm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          operation,
    input  logic [31:0]         address,
    input  logic [5:0]          prefix_len,
    input  logic [31:0]         new_value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                found,
    output logic [31:0]         result_value,
    output logic                table_full,
    output lpm_pkg::lpm_query_t query,
    output lpm_pkg::lpm_cmd_t   cmd,
    output lpm_pkg::lpm_carry_t head,
    input  lpm_pkg::lpm_carry_t tail
);
    import lpm_pkg::*;

    lpm_state_t  state_reg;
    lpm_state_t  state_next;
    lpm_op_t     op_reg;
    lpm_query_t  query_reg;
    logic [31:0] value_reg;
    lpm_carry_t  res_reg;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic        found_reg;
    logic [31:0] result_value_reg;
    logic        table_full_reg;

    lpm_op_t     in_op;
    logic        in_len_ok;
    logic        walk_needed;
    logic [5:0]  in_len;
    logic        accept;
    logic        out_free;
    logic        fire;
    logic        res_found;
    logic [31:0] res_value;
    logic        res_full;

    // Decode the incoming request.
    always_comb
    begin
        in_op       = lpm_op_t'(operation);
        in_len_ok   = (prefix_len <= LPM_MAX_LEN);
        walk_needed = (in_op == OP_LOOKUP)
                      || (((in_op == OP_ADD) || (in_op == OP_DELETE)) && in_len_ok);
        in_len      = in_len_ok ? prefix_len : LPM_MAX_LEN;
        accept      = in_valid && (state_reg == ST_IDLE);
        out_free    = !out_valid_reg || out_ready;
        fire        = (state_reg == ST_DONE) && out_free;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid) begin
                    state_next = walk_needed ? ST_LAUNCH : ST_DONE;
                end
            end
            ST_LAUNCH: state_next = ST_WALK;
            ST_WALK:
            begin
                if (tail.active) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the state machine: token launch, result and table update.
    always_comb
    begin
        in_ready        = (state_reg == ST_IDLE);
        head            = '0;
        head.active     = (state_reg == ST_LAUNCH);
        res_found       = 1'b0;
        res_value       = LPM_ALL_ONES;
        res_full        = 1'b0;
        cmd             = '0;
        cmd.key         = query_reg.key;
        cmd.len         = query_reg.len;
        cmd.value       = value_reg;
        unique case (op_reg)
            OP_LOOKUP:
            begin
                res_found = res_reg.hit;
                if (res_reg.hit) begin
                    res_value = res_reg.best_value;
                end
            end
            OP_ADD:
            begin
                if (res_reg.exact_seen) begin
                    cmd.write_exact = fire;
                end else if (res_reg.free_seen) begin
                    cmd.write_free = fire;
                end else begin
                    res_full = 1'b1;
                end
            end
            OP_DELETE:
            begin
                res_found       = res_reg.exact_seen;
                cmd.clear_exact = fire && res_reg.exact_seen;
            end
            OP_NONE:
            begin
                res_found = 1'b0;
            end
            default:
            begin
                res_found = 1'b0;
            end
        endcase
        out_valid_next = fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Held request; a request that needs no search is recorded as no operation.
    always_ff @(posedge clk)
    begin
        if (accept) begin
            op_reg            <= walk_needed ? in_op : OP_NONE;
            query_reg.address <= address;
            query_reg.len     <= in_len;
            query_reg.key     <= address & prefix_mask(in_len);
            value_reg         <= new_value;
        end
    end

    // Token as it leaves the end of the chain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            res_reg <= '0;
        end else if ((state_reg == ST_WALK) && tail.active) begin
            res_reg <= tail;
        end
    end

    // Result register, loaded when the finished transaction can be handed on.
    always_ff @(posedge clk)
    begin
        if (fire) begin
            found_reg        <= res_found;
            result_value_reg <= res_value;
            table_full_reg   <= res_full;
        end
    end

    assign query        = query_reg;
    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign result_value = result_value_reg;
    assign table_full   = table_full_reg;

endmodule

/* design/ipv4_longest_prefix_match_table.sv */
// Top level of the IPv4 longest-prefix-match table: controller plus a chain of
// entry cells. Depends on lpm_pkg, lpm_cell and lpm_ctrl.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one request per transaction:
//   operation (lookup, add or delete), address, prefix_len and new_value.
//   The output channel (out_valid/out_ready) returns one result per request:
//   found, result_value and table_full.
//   A request is served by a search token that walks the row of entry cells,
//   one cell per clock cycle; the table update is then broadcast to every cell.
//   A request that needs no search skips the walk and goes straight to the
//   result. One request is in flight at a time: the next request is not
//   accepted until the last one has been handed to the output register.
//   The result sits in an output register: the next request is accepted while
//   a result still waits. If the receiver stalls, a finished request waits
//   until the output register is taken before it updates the table.
//   Reset (rst_n, asynchronous, active low) empties the table at once and
//   clears both channels; no clearing pass is needed.
module ipv4_longest_prefix_match_table #(
    parameter int ENTRIES = lpm_pkg::LPM_ENTRIES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [31:0] address,
    input  logic [5:0]  prefix_len,
    input  logic [31:0] new_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        found,
    output logic [31:0] result_value,
    output logic        table_full
);
    import lpm_pkg::*;

    lpm_query_t query;
    lpm_cmd_t   cmd;
    lpm_carry_t chain [ENTRIES+1];

    // Request handling and result register.
    lpm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .address      (address),
        .prefix_len   (prefix_len),
        .new_value    (new_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .found        (found),
        .result_value (result_value),
        .table_full   (table_full),
        .query        (query),
        .cmd          (cmd),
        .head         (chain[0]),
        .tail         (chain[ENTRIES])
    );

    // Row of entry cells; the token moves one cell per cycle.
    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        lpm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .query     (query),
            .cmd       (cmd),
            .carry_in  (chain[i]),
            .carry_out (chain[i+1])
        );
    end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for ipv4_longest_prefix_match_table: directed, length-limit,
// table-full and random transactions are compared with a predictor of the prefix table.
// Depends on lpm_pkg and the ipv4_longest_prefix_match_table RTL.
module tb_top;
    import lpm_pkg::*;

    localparam int ENTRIES      = 64;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = ENTRIES + 10;
    localparam int PREFIX_POOL  = 80;

    typedef struct {
        logic        found;
        logic [31:0] value;
        logic        full;
    } route_result_t;

    typedef struct {
        logic [31:0] addr;
        logic [5:0]  len;
    } prefix_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_ready;
    logic [1:0]  operation    = OP_LOOKUP;
    logic [31:0] address      = 32'd0;
    logic [5:0]  prefix_len   = 6'd0;
    logic [31:0] new_value    = 32'd0;
    logic        out_valid;
    logic        out_ready    = 1'b0;
    logic        found;
    logic [31:0] result_value;
    logic        table_full;

    // Predicted contents of the prefix table.
    logic        route_valid [ENTRIES];
    logic [31:0] route_key   [ENTRIES];
    logic [5:0]  route_len   [ENTRIES];
    logic [31:0] route_value [ENTRIES];

    route_result_t expected_results [$];
    prefix_t       known_prefixes [$];
    bit            idle_enabled = 1'b1;
    int            stall_left   = 0;
    int            failures     = 0;
    int            cycle_count  = 0;

    ipv4_longest_prefix_match_table #(
        .ENTRIES(ENTRIES)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .operation(operation),
        .address(address),
        .prefix_len(prefix_len),
        .new_value(new_value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .found(found),
        .result_value(result_value),
        .table_full(table_full)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Network mask for a length, first network bit at bit 31.
    function automatic logic [31:0] network_mask(input logic [5:0] len);
        if (len >= 6'd32)
        begin
            return 32'hFFFF_FFFF;
        end
        return ~(32'hFFFF_FFFF >> len);
    endfunction

    // Index of the valid entry holding exactly this key and length, or -1.
    function automatic int find_route(input logic [31:0] key, input logic [5:0] len);
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (route_valid[i] && route_len[i] == len && route_key[i] == key)
            begin
                return i;
            end
        end
        return -1;
    endfunction

    // Applies one request to the predicted table and returns its expected result.
    function automatic route_result_t predict_route(input lpm_op_t op, input logic [31:0] addr,
                                                    input logic [5:0] len,
                                                    input logic [31:0] value);
        route_result_t res;
        logic [5:0]    limit;
        logic [5:0]    best_len;
        logic [31:0]   key;
        int            best;
        int            slot;
        res.found = 1'b0;
        res.value = LPM_ALL_ONES;
        res.full  = 1'b0;
        best      = -1;
        slot      = -1;
        best_len  = 6'd0;
        key       = addr & network_mask(len);
        case (op)
            OP_LOOKUP:
            begin
                // Longest matching prefix no longer than the requested length.
                limit = (len > LPM_MAX_LEN) ? LPM_MAX_LEN : len;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (route_valid[i] && route_len[i] <= limit
                        && route_key[i] == (addr & network_mask(route_len[i]))
                        && (best < 0 || route_len[i] > best_len))
                    begin
                        best     = i;
                        best_len = route_len[i];
                    end
                end
                if (best >= 0)
                begin
                    res.found = 1'b1;
                    res.value = route_value[best];
                end
            end
            OP_ADD:
            begin
                // Lengths beyond 32 are ignored; an existing prefix is overwritten.
                if (len <= LPM_MAX_LEN)
                begin
                    best = find_route(key, len);
                    if (best >= 0)
                    begin
                        route_value[best] = value;
                    end
                    else
                    begin
                        for (int i = ENTRIES - 1; i >= 0; i--)
                        begin
                            if (!route_valid[i])
                            begin
                                slot = i;
                            end
                        end
                        if (slot >= 0)
                        begin
                            route_valid[slot] = 1'b1;
                            route_key[slot]   = key;
                            route_len[slot]   = len;
                            route_value[slot] = value;
                        end
                        else
                        begin
                            res.full = 1'b1;
                        end
                    end
                end
            end
            OP_DELETE:
            begin
                if (len <= LPM_MAX_LEN)
                begin
                    best = find_route(key, len);
                    if (best >= 0)
                    begin
                        route_valid[best] = 1'b0;
                        res.found         = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    // Keeps the network bits of a prefix and randomises the host bits.
    function automatic logic [31:0] with_host_bits(input logic [31:0] addr,
                                                   input logic [5:0] len);
        return (addr & network_mask(len)) | ($urandom & ~network_mask(len));
    endfunction

    function automatic logic [5:0] random_prefix_len();
        return ($urandom_range(0, 3) == 0) ? 6'd32 : 6'($urandom_range(0, 32));
    endfunction

    // Lookup lengths: mostly full, some shorter, a few past 32 to hit saturation.
    function automatic logic [5:0] lookup_len();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 5)
        begin
            return 6'd32;
        end
        if (roll < 9)
        begin
            return 6'($urandom_range(0, 32));
        end
        return 6'($urandom_range(33, 63));
    endfunction

    function automatic void remember_prefix(input logic [31:0] addr, input logic [5:0] len);
        prefix_t entry;
        entry.addr = addr;
        entry.len  = len;
        known_prefixes.push_back(entry);
        if (known_prefixes.size() > PREFIX_POOL)
        begin
            void'(known_prefixes.pop_front());
        end
    endfunction

    // Sends one request transaction and records its expected result on acceptance.
    // The valid stays high on return so that a following request can follow at once.
    task automatic send_request(input lpm_op_t op, input logic [31:0] addr,
                                input logic [5:0] len, input logic [31:0] value);
        int gap;
        int roll;
        gap  = 0;
        roll = $urandom_range(0, 99);
        if (idle_enabled && roll < 30)
        begin
            gap = (roll < 5) ? $urandom_range(4, 70) : $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        address    <= addr;
        prefix_len <= len;
        new_value  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        expected_results.push_back(predict_route(op, addr, len, value));
    endtask

    // Stops sending and waits until every outstanding result has been checked.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (expected_results.size() != 0);
    endtask

    // Nested prefixes, overwrite, delete, default route and all-ones values.
    task automatic test_directed_routes();
        send_request(OP_LOOKUP, 32'h0A01_0203, 6'd32, 32'd0);
        send_request(OP_ADD,    32'h0A01_0203, 6'd8,  32'h1111_0008);
        send_request(OP_ADD,    32'h0A01_FFFF, 6'd16, 32'h1111_0016);
        send_request(OP_ADD,    32'h0A01_0203, 6'd32, 32'h1111_0032);
        send_request(OP_ADD,    32'hDEAD_BEEF, 6'd0,  32'h1111_0000);
        send_request(OP_LOOKUP, 32'h0A01_0203, 6'd32, 32'd0);
        send_request(OP_LOOKUP, 32'h0A01_0203, 6'd31, 32'd0);
        send_request(OP_LOOKUP, 32'h0A01_0203, 6'd16, 32'd0);
        send_request(OP_LOOKUP, 32'h0A01_0203, 6'd15, 32'd0);
        send_request(OP_LOOKUP, 32'h0A01_0203, 6'd7,  32'd0);
        send_request(OP_LOOKUP, 32'hC0A8_0001, 6'd32, 32'd0);
        send_request(OP_ADD,    32'h0A01_0000, 6'd16, 32'h2222_0016);
        send_request(OP_LOOKUP, 32'h0A01_7777, 6'd24, 32'd0);
        send_request(OP_DELETE, 32'h0A01_1234, 6'd16, 32'hFFFF_FFFF);
        send_request(OP_DELETE, 32'h0A01_0000, 6'd16, 32'd0);
        send_request(OP_LOOKUP, 32'h0A01_0203, 6'd31, 32'd0);
        send_request(OP_ADD,    32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFF);
        send_request(OP_LOOKUP, 32'hFFFF_FFFF, 6'd32, 32'd0);
        send_request(OP_ADD,    32'h8000_0000, 6'd1,  32'd0);
        send_request(OP_LOOKUP, 32'h8123_4567, 6'd32, 32'd0);
    endtask

    // Lengths beyond 32 and the unused operation code.
    task automatic test_length_limits();
        send_request(OP_LOOKUP, 32'h0A01_0203, 6'd63, 32'd0);
        send_request(OP_LOOKUP, 32'h0A01_0203, 6'd33, 32'd0);
        send_request(OP_ADD,    32'h0A01_0203, 6'd40, 32'h3333_0040);
        send_request(OP_DELETE, 32'h0A01_0203, 6'd33, 32'd0);
        send_request(OP_DELETE, 32'h0A01_0203, 6'd63, 32'd0);
        send_request(OP_NONE,   32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF);
        send_request(OP_LOOKUP, 32'h0A01_0203, 6'd32, 32'd0);
    endtask

    // Fills the table past capacity, overwrites while full, then deletes the prefixes it added.
    task automatic test_table_full();
        for (int k = 0; k < ENTRIES + 6; k++)
        begin
            send_request(OP_ADD, 32'hC600_0000 + k, 6'd32, $urandom);
        end
        send_request(OP_ADD,    32'hC600_0000, 6'd32, 32'h4444_0000);
        send_request(OP_ADD,    32'hC600_1FFF, 6'd20, 32'h4444_0020);
        send_request(OP_LOOKUP, 32'hC600_0000, 6'd32, 32'd0);
        for (int k = 0; k < ENTRIES + 6; k++)
        begin
            send_request(OP_DELETE, 32'hC600_0000 + k, 6'd32, $urandom);
        end
    endtask

    // Random traffic built mostly around prefixes already added, so that lookups
    // hit nested routes and deletes find their entries.
    task automatic test_random_traffic(input int count);
        prefix_t     pick;
        logic [31:0] addr;
        logic [5:0]  len;
        int          roll;
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            if (known_prefixes.size() != 0)
            begin
                pick = known_prefixes[$urandom_range(0, known_prefixes.size() - 1)];
            end
            if (known_prefixes.size() == 0 || roll < 22)
            begin
                addr = $urandom;
                len  = random_prefix_len();
                remember_prefix(addr, len);
                send_request(OP_ADD, addr, len, $urandom);
            end
            else if (roll < 32)
            begin
                len  = random_prefix_len();
                addr = with_host_bits(pick.addr, len);
                remember_prefix(addr, len);
                send_request(OP_ADD, addr, len, $urandom);
            end
            else if (roll < 42)
            begin
                send_request(OP_ADD, with_host_bits(pick.addr, pick.len), pick.len, $urandom);
            end
            else if (roll < 72)
            begin
                send_request(OP_LOOKUP, with_host_bits(pick.addr, pick.len), lookup_len(),
                             $urandom);
            end
            else if (roll < 85)
            begin
                send_request(OP_DELETE, with_host_bits(pick.addr, pick.len), pick.len,
                             $urandom);
            end
            else if (roll < 90)
            begin
                send_request(OP_LOOKUP, $urandom, lookup_len(), $urandom);
            end
            else if (roll < 93)
            begin
                send_request(OP_DELETE, $urandom, random_prefix_len(), $urandom);
            end
            else if (roll < 96)
            begin
                send_request(OP_NONE, $urandom, 6'($urandom_range(0, 63)), $urandom);
            end
            else
            begin
                len = 6'($urandom_range(33, 63));
                if (roll[0])
                begin
                    send_request(OP_ADD, $urandom, len, $urandom);
                end
                else
                begin
                    send_request(OP_DELETE, $urandom, len, $urandom);
                end
            end
        end
    endtask

    // Receiver: short random stalls plus the occasional long one.
    always @(posedge clk)
    begin
        int roll;
        roll = $urandom_range(0, 99);
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (idle_enabled && roll == 0)
        begin
            stall_left <= $urandom_range(10, 40);
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= !(idle_enabled && roll < 21);
        end
    end

    // Compares each result transaction with the oldest expectation.
    always @(posedge clk)
    begin
        route_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: found %0d, result_value %h, table_full %0d",
                       found, result_value, table_full);
                failures++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (found !== want.found)
                begin
                    $error("found: expected %0d, actual %0d", want.found, found);
                    failures++;
                end
                if (result_value !== want.value)
                begin
                    $error("result_value: expected %h, actual %h", want.value, result_value);
                    failures++;
                end
                if (table_full !== want.full)
                begin
                    $error("table_full: expected %0d, actual %0d", want.full, table_full);
                    failures++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            route_valid[i] = 1'b0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_routes();
        test_length_limits();
        wait_for_results();
        test_table_full();
        test_random_traffic(80);

        // A stretch with neither side idling, then a full drain before resuming.
        idle_enabled <= 1'b0;
        test_random_traffic(60);
        wait_for_results();
        idle_enabled <= 1'b1;
        test_random_traffic(90);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
